/* src/hvn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared types, constants and helpers of the height map vertex/normal stream.
// ----------------------------------------------------------------------------
package hvn_pkg;

   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int MAX_ROWS_DEF    = 1024;

   // widest grid index and clamped size over the whole parameter range
   localparam int POS_W  = 12;
   localparam int SIZE_W = 13;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMNS,
      CSR_ROWS,
      CSR_MODE,
      CSR_BASE,
      CSR_STEP,
      CSR_SPACING,
      CSR_INV_SPACING
   } hvn_csr_type;

   // one grid point to be finished by the back end
   typedef struct packed {
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
      logic signed [31:0] zc;
      logic signed [31:0] zl;
      logic signed [31:0] zr;
      logic signed [31:0] zu;
      logic signed [31:0] zd;
      logic               last;
   } hvn_job_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_READ,
      F_WRITE,
      F_PUSH
   } hvn_front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_MUL,
      B_ROUND,
      B_SQUARE,
      B_SUM,
      B_ROOT,
      B_DIVSET,
      B_DIVIDE,
      B_OUT
   } hvn_back_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sh0000_7FFF_FFFF)
         r = 32'sh7FFF_FFFF;
      else if (v < -48'sh0000_8000_0000)
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/hvn_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_queue
// Short job queue between the sample front end and the normal back end.
// ----------------------------------------------------------------------------
module hvn_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire hvn_pkg::hvn_job_type push_job,
   output logic                     full,
   input  wire logic                pop,
   output hvn_pkg::hvn_job_type     head_job,
   output logic                     empty
);
   import hvn_pkg::*;

   hvn_job_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty))
         count_in = count_ff + 1'b1;
      else if (!(push && !full) && (pop && !empty))
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* src/hvn_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_front
// Takes samples, scales heights unless in direct mode, keeps the two line
// buffers and queues the grid points that each sample completes.
// ----------------------------------------------------------------------------
module hvn_front #(
   parameter int MAX_COLUMNS = hvn_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = hvn_pkg::MAX_ROWS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [31:0]                req_tdata,
   input  wire logic                       req_tuser,
   input  wire logic [hvn_pkg::SIZE_W-1:0] cols,
   input  wire logic [hvn_pkg::SIZE_W-1:0] rows,
   input  wire logic                       direct_mode,
   input  wire logic signed [31:0]         height_base,
   input  wire logic signed [31:0]         height_step,
   output logic                            push,
   output hvn_pkg::hvn_job_type            push_job,
   input  wire logic                       queue_full
);
   import hvn_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int AW = CW + 1;

   hvn_front_state_type state_ff, state_in;

   logic [CW-1:0]       col_cnt_ff;
   logic [RW-1:0]       row_cnt_ff;
   logic [CW-1:0]       c_ff;
   logic [RW-1:0]       r_ff;
   logic [31:0]         sample_ff;
   logic [2:0]          rd_idx_ff;
   logic [1:0]          jk_ff;
   logic signed [40:0]  prod_ff;
   logic signed [31:0]  z_ff;
   logic signed [31:0]  nw0_ff, nw1_ff;
   logic signed [31:0]  rdv_ff [6];
   logic [31:0]         mem [2**AW];
   logic [31:0]         rd_data_ff;

   logic [SIZE_W-1:0]   cc, rc, nc, nr;
   logic [CW-1:0]       p, pm;
   logic [AW-1:0]       rd_addr;
   logic                mem_we;
   logic                accept;
   logic [3:0]          en;
   logic                advance;
   logic                on_last_row, above_one, left_gt0;
   hvn_job_type         job [4];

   assign accept = req_tvalid && req_tready;

   // row and column of the sample being accepted, and the counters after it
   always_comb begin
      cc = req_tuser ? '0 : SIZE_W'(col_cnt_ff);
      rc = req_tuser ? '0 : SIZE_W'(row_cnt_ff);
      if (cc >= cols) begin
         cc = '0;
         rc = rc + 1'b1;
      end
      if (rc >= rows) begin
         rc = '0;
      end
      nc = cc + 1'b1;
      nr = rc;
      if (nc >= cols) begin
         nc = '0;
         nr = rc + 1'b1;
         if (nr >= rows) begin
            nr = '0;
         end
      end
   end

   assign p  = c_ff - 1'b1;
   assign pm = c_ff - 2'd2;

   always_comb begin
      case (rd_idx_ff)
         3'd0: rd_addr = {r_ff[0], c_ff};
         3'd1: rd_addr = {~r_ff[0], c_ff};
         3'd2: rd_addr = {~r_ff[0], p};
         3'd3: rd_addr = {~r_ff[0], pm};
         3'd4: rd_addr = {r_ff[0], pm};
         3'd5: rd_addr = {r_ff[0], p};
         default: rd_addr = {r_ff[0], c_ff};
      endcase
   end

   // points completed by this sample, in emission order
   assign on_last_row = (SIZE_W'(r_ff) == rows - 1'b1);
   assign above_one   = (r_ff > RW'(1));
   assign left_gt0    = (c_ff > CW'(1));
   assign en[0] = (r_ff != '0) && (c_ff != '0);
   assign en[1] = en[0] && on_last_row;
   assign en[2] = (r_ff != '0) && (SIZE_W'(c_ff) == cols - 1'b1);
   assign en[3] = en[2] && on_last_row;

   always_comb begin
      job[0].col  = POS_W'(p);
      job[0].row  = POS_W'(r_ff - 1'b1);
      job[0].zc   = rdv_ff[2];
      job[0].zl   = left_gt0 ? rdv_ff[3] : rdv_ff[2];
      job[0].zr   = rdv_ff[1];
      job[0].zu   = above_one ? nw0_ff : rdv_ff[2];
      job[0].zd   = nw1_ff;
      job[0].last = !en[1] && !en[2];

      job[1].col  = POS_W'(p);
      job[1].row  = POS_W'(r_ff);
      job[1].zc   = nw1_ff;
      job[1].zl   = left_gt0 ? rdv_ff[4] : nw1_ff;
      job[1].zr   = z_ff;
      job[1].zu   = rdv_ff[2];
      job[1].zd   = nw1_ff;
      job[1].last = !en[2];

      job[2].col  = POS_W'(c_ff);
      job[2].row  = POS_W'(r_ff - 1'b1);
      job[2].zc   = rdv_ff[1];
      job[2].zl   = rdv_ff[2];
      job[2].zr   = rdv_ff[1];
      job[2].zu   = above_one ? rdv_ff[0] : rdv_ff[1];
      job[2].zd   = z_ff;
      job[2].last = !en[3];

      job[3].col  = POS_W'(c_ff);
      job[3].row  = POS_W'(r_ff);
      job[3].zc   = z_ff;
      job[3].zl   = rdv_ff[5];
      job[3].zr   = z_ff;
      job[3].zu   = rdv_ff[1];
      job[3].zd   = z_ff;
      job[3].last = 1'b1;
   end

   assign push_job = job[jk_ff];
   assign advance  = !en[jk_ff] || !queue_full;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (req_tvalid) state_in = F_READ;
         F_READ:  if (rd_idx_ff == 3'd5) state_in = F_WRITE;
         F_WRITE: state_in = F_PUSH;
         F_PUSH:  if (advance && jk_ff == 2'd3) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      push       = 1'b0;
      case (state_ff)
         F_IDLE:  req_tready = 1'b1;
         F_WRITE: mem_we = 1'b1;
         F_PUSH:  push = en[jk_ff] && !queue_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         rd_idx_ff  <= '0;
         jk_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            col_cnt_ff <= nc[CW-1:0];
            row_cnt_ff <= nr[RW-1:0];
            rd_idx_ff  <= '0;
            jk_ff      <= '0;
         end
         if (state_ff == F_READ) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (state_ff == F_PUSH && advance) begin
            jk_ff <= jk_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff      <= cc[CW-1:0];
         r_ff      <= rc[RW-1:0];
         sample_ff <= req_tdata;
      end
      if (state_ff == F_READ) begin
         if (rd_idx_ff == 3'd0) begin
            prod_ff <= $signed({1'b0, sample_ff[7:0]}) * height_step;
         end
         if (rd_idx_ff == 3'd1) begin
            z_ff <= direct_mode ? $signed(sample_ff)
                                : sat32(48'(height_base) + 48'(prod_ff));
         end
         if (rd_idx_ff != 3'd0) begin
            rdv_ff[3'(rd_idx_ff - 3'd1)] <= rd_data_ff;
         end
      end
      if (state_ff == F_WRITE) begin
         rdv_ff[5] <= rd_data_ff;
      end
      if (state_ff == F_PUSH && advance && jk_ff == 2'd3) begin
         nw0_ff <= rdv_ff[0];
         nw1_ff <= z_ff;
      end
   end

   // line buffers, row parity selects the half
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (mem_we) begin
         mem[{r_ff[0], c_ff}] <= z_ff;
      end
   end

endmodule

`default_nettype wire

/* src/hvn_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_back
// Position, slopes, vector length (iterative root) and normal components
// (iterative division) of one grid point at a time.
// ----------------------------------------------------------------------------
module hvn_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hvn_pkg::hvn_job_type       head_job,
   input  wire logic                       empty,
   output logic                            pop,
   input  wire logic [hvn_pkg::SIZE_W-1:0] cols,
   input  wire logic [hvn_pkg::SIZE_W-1:0] rows,
   input  wire logic [30:0]                grid_spacing,
   input  wire logic [30:0]                inverse_twice_spacing,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [9:0]                      point_column,
   output logic [9:0]                      point_row,
   output logic signed [31:0]              pos_x,
   output logic signed [31:0]              pos_y,
   output logic signed [31:0]              pos_z,
   output logic signed [15:0]              normal_x,
   output logic signed [15:0]              normal_y,
   output logic [14:0]                     normal_z,
   output logic                            last_of_burst
);
   import hvn_pkg::*;

   hvn_back_state_type state_ff, state_in;

   hvn_job_type        job_ff;
   logic signed [45:0] xprod_ff, yprod_ff;
   logic signed [64:0] sxp_ff, syp_ff;
   logic signed [31:0] x_ff, y_ff, sx_ff, sy_ff;
   logic [31:0]        ax_ff, ay_ff;
   logic [63:0]        sqx_ff, sqy_ff;
   logic [63:0]        v_ff, root_ff, bit_ff;
   logic [4:0]         step_ff;
   logic [47:0]        remx_ff, remy_ff, remz_ff;
   logic [15:0]        qx_ff, qy_ff, qz_ff;
   logic               out_valid_ff;

   logic signed [13:0] dx, dy;
   logic signed [31:0] sx_new, sy_new;
   logic [63:0]        rb;
   logic [47:0]        trial;
   logic [31:0]        len;
   logic               load_out;

   function automatic logic signed [31:0] slope_round(input logic signed [64:0] v);
      logic [64:0]        m;
      logic [64:0]        q;
      logic signed [31:0] r;
      m = v[64] ? (~v + 65'd1) : v;
      q = (m + 65'h8000) >> 16;
      if (!v[64])
         r = (q > 65'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
      else
         r = (q > 65'h8000_0000) ? 32'sh8000_0000 : $signed(~q[31:0] + 32'd1);
      return r;
   endfunction

   function automatic logic [31:0] mag(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic signed [15:0] comp(input logic [15:0] q, input logic neg);
      logic [15:0] s;
      s = (q > 16'd32767) ? 16'd32767 : q;
      return neg ? $signed(~s + 16'd1) : $signed(s);
   endfunction

   assign dx    = 14'(job_ff.col) - 14'(cols[SIZE_W-1:1]);
   assign dy    = 14'(rows[SIZE_W-1:1]) - 14'(job_ff.row);
   assign sx_new = slope_round(sxp_ff);
   assign sy_new = slope_round(syp_ff);
   assign rb    = root_ff + bit_ff;
   assign len   = root_ff[31:0];
   assign trial = 48'(len) << step_ff[3:0];
   assign load_out = (state_ff == B_OUT) && (!out_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:   if (!empty) state_in = B_MUL;
         B_MUL:    state_in = B_ROUND;
         B_ROUND:  state_in = B_SQUARE;
         B_SQUARE: state_in = B_SUM;
         B_SUM:    state_in = B_ROOT;
         B_ROOT:   if (step_ff == '0) state_in = B_DIVSET;
         B_DIVSET: state_in = B_DIVIDE;
         B_DIVIDE: if (step_ff == '0) state_in = B_OUT;
         B_OUT:    if (load_out) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop = 1'b0;
      case (state_ff)
         B_IDLE:  pop = !empty;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (load_out)
            out_valid_ff <= 1'b1;
         else if (rsp_tready)
            out_valid_ff <= 1'b0;
         case (state_ff)
            B_SUM:    step_ff <= 5'd31;
            B_DIVSET: step_ff <= 5'd15;
            B_ROOT, B_DIVIDE: step_ff <= step_ff - 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: job_ff <= head_job;
         B_MUL: begin
            xprod_ff <= dx * $signed({1'b0, grid_spacing});
            yprod_ff <= dy * $signed({1'b0, grid_spacing});
            sxp_ff   <= (33'(job_ff.zr) - 33'(job_ff.zl)) *
                        $signed({1'b0, inverse_twice_spacing});
            syp_ff   <= (33'(job_ff.zd) - 33'(job_ff.zu)) *
                        $signed({1'b0, inverse_twice_spacing});
         end
         B_ROUND: begin
            x_ff  <= sat32(48'(xprod_ff));
            y_ff  <= sat32(48'(yprod_ff));
            sx_ff <= sx_new;
            sy_ff <= sy_new;
            ax_ff <= mag(sx_new);
            ay_ff <= mag(sy_new);
         end
         B_SQUARE: begin
            sqx_ff <= ax_ff * ax_ff;
            sqy_ff <= ay_ff * ay_ff;
         end
         B_SUM: begin
            v_ff    <= sqx_ff + sqy_ff + 64'h1_0000_0000;
            root_ff <= '0;
            bit_ff  <= 64'h4000_0000_0000_0000;
         end
         B_ROOT: begin
            if (v_ff >= rb) begin
               v_ff    <= v_ff - rb;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         B_DIVSET: begin
            remx_ff <= {1'b0, ax_ff, 15'd0} + 48'(len >> 1);
            remy_ff <= {1'b0, ay_ff, 15'd0} + 48'(len >> 1);
            remz_ff <= {1'b0, 32'd65536, 15'd0} + 48'(len >> 1);
            qx_ff   <= '0;
            qy_ff   <= '0;
            qz_ff   <= '0;
         end
         B_DIVIDE: begin
            if (remx_ff >= trial) remx_ff <= remx_ff - trial;
            if (remy_ff >= trial) remy_ff <= remy_ff - trial;
            if (remz_ff >= trial) remz_ff <= remz_ff - trial;
            qx_ff <= {qx_ff[14:0], remx_ff >= trial};
            qy_ff <= {qy_ff[14:0], remy_ff >= trial};
            qz_ff <= {qz_ff[14:0], remz_ff >= trial};
         end
         default: ;
      endcase
      if (load_out) begin
         point_column  <= job_ff.col[9:0];
         point_row     <= job_ff.row[9:0];
         pos_x         <= x_ff;
         pos_y         <= y_ff;
         pos_z         <= job_ff.zc;
         normal_x      <= comp(qx_ff, sx_ff[31]);
         normal_y      <= comp(qy_ff, sy_ff[31]);
         normal_z      <= (qz_ff > 16'd32767) ? 15'd32767 : qz_ff[14:0];
         last_of_burst <= job_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

`default_nettype wire

/* src/heightmap_vertex_normal_stream.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_stream
// Height samples in raster order in, grid points with position and unit
// normal out, one row and one column behind.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                   tuser        tlast
//  req_     in         height_sample (32)      frame_start  -
//  rsp_     out        point fields (163 + 5)  -            last_of_burst
//  csr_     in         write only, index 0..6  -            -
//
//  a sample passes through the front end as accept, six line buffer
//  reads, one write and four push slots, a push slot waiting while the
//  queue is full; each point then passes through the back end, with a
//  32-step root and 16-step divider, plus any wait on rsp_tready.
//  a four-entry job queue lets the front take samples while points finish.
//  synchronous reset clears counters, handshakes and state and loads CSR
//  defaults; data and line buffer contents stay undefined until written.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_stream #(
   parameter int MAX_COLUMNS = hvn_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = hvn_pkg::MAX_ROWS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [31:0]                     req_tdata,  // height_sample
   input  wire logic                            req_tuser,  // frame_start
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // point_column, point_row, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z
   output logic [167:0]                         rsp_tdata,
   output logic                                 rsp_tlast,
   input  wire logic                            csr_we,
   input  wire logic [hvn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hvn_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hvn_pkg::*;

   logic [10:0]        grid_columns_ff;
   logic [10:0]        grid_rows_ff;
   logic               direct_mode_ff;
   logic signed [31:0] height_base_ff;
   logic signed [31:0] height_step_ff;
   logic [30:0]        grid_spacing_ff;
   logic [30:0]        inv_spacing_ff;

   logic [SIZE_W-1:0]  cols, rows;
   logic               push, queue_full, pop, empty;
   hvn_job_type        push_job, head_job;

   logic [9:0]         point_column, point_row;
   logic signed [31:0] pos_x, pos_y, pos_z;
   logic signed [15:0] normal_x, normal_y;
   logic [14:0]        normal_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= 11'd256;
         grid_rows_ff    <= 11'd256;
         direct_mode_ff  <= 1'b0;
         height_base_ff  <= '0;
         height_step_ff  <= 32'sd256;
         grid_spacing_ff <= 31'd65536;
         inv_spacing_ff  <= 31'd32768;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLUMNS:     grid_columns_ff <= csr_wdata[10:0];
            CSR_ROWS:        grid_rows_ff    <= csr_wdata[10:0];
            CSR_MODE:        direct_mode_ff  <= csr_wdata[0];
            CSR_BASE:        height_base_ff  <= csr_wdata;
            CSR_STEP:        height_step_ff  <= csr_wdata;
            CSR_SPACING:     grid_spacing_ff <= csr_wdata[30:0];
            CSR_INV_SPACING: inv_spacing_ff  <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // map size clamped to [2, max]
   always_comb begin
      cols = SIZE_W'(grid_columns_ff);
      if (cols < SIZE_W'(2))
         cols = SIZE_W'(2);
      else if (cols > SIZE_W'(MAX_COLUMNS))
         cols = SIZE_W'(MAX_COLUMNS);
      rows = SIZE_W'(grid_rows_ff);
      if (rows < SIZE_W'(2))
         rows = SIZE_W'(2);
      else if (rows > SIZE_W'(MAX_ROWS))
         rows = SIZE_W'(MAX_ROWS);
   end

   hvn_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cols        (cols),
      .rows        (rows),
      .direct_mode (direct_mode_ff),
      .height_base (height_base_ff),
      .height_step (height_step_ff),
      .push        (push),
      .push_job    (push_job),
      .queue_full  (queue_full)
   );

   hvn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty)
   );

   hvn_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_job              (head_job),
      .empty                 (empty),
      .pop                   (pop),
      .cols                  (cols),
      .rows                  (rows),
      .grid_spacing          (grid_spacing_ff),
      .inverse_twice_spacing (inv_spacing_ff),
      .rsp_tvalid            (rsp_tvalid),
      .rsp_tready            (rsp_tready),
      .point_column          (point_column),
      .point_row             (point_row),
      .pos_x                 (pos_x),
      .pos_y                 (pos_y),
      .pos_z                 (pos_z),
      .normal_x              (normal_x),
      .normal_y              (normal_y),
      .normal_z              (normal_z),
      .last_of_burst         (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, normal_z, normal_y, normal_x, pos_z, pos_y, pos_x,
                       point_row, point_column};

endmodule

`default_nettype wire
